FILE: design/smcm_pkg.sv
`default_nettype none

package smcm_pkg;

  localparam int DIM   = 64;
  localparam int NNZ_A = 1024;

  localparam int ROW_W  = 6;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;
  localparam int IDX_W  = $clog2(DIM);
  localparam int A_AW   = (NNZ_A > 1) ? $clog2(NNZ_A) : 1;
  localparam int CNT_W  = $clog2(NNZ_A + 1);

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]        r;
    logic [ROW_W-1:0]        c;
    logic signed [VAL_W-1:0] v;
  } a_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // an item is transferred this cycle
    logic init;   // end-column item transferred: reset walk counters
    logic a_rd;   // read the next stored A entry
    logic b_rd;   // read B and C vectors for that entry
    logic mul;    // form the product
    logic acc;    // accumulate into the C vector
    logic scan;   // read the next C vector row
    logic fin;    // deliver the final result and clear the vectors
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_empty;
    logic entry_last;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/smcm_ctrl.sv
`default_nettype none

module smcm_ctrl
  import smcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] req_type,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_A_RD  = 3'd1;
  localparam logic [2:0] S_B_RD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;

  assign take = start && (state == S_IDLE);
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take && (req_type == REQ_END)) begin
          state_next = stat.a_empty ? S_SCAN : S_A_RD;
        end
      end
      S_A_RD:  state_next = S_B_RD;
      S_B_RD:  state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = stat.entry_last ? S_SCAN : S_A_RD;
      S_SCAN:  state_next = stat.scan_last ? S_DRAIN : S_SCAN;
      S_DRAIN: state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.take = take;
    cmd.init = take && (req_type == REQ_END);
    cmd.a_rd = (state == S_A_RD);
    cmd.b_rd = (state == S_B_RD);
    cmd.mul  = (state == S_MUL);
    cmd.acc  = (state == S_ACC);
    cmd.scan = (state == S_SCAN);
    cmd.fin  = (state == S_FIN);
  end

  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_IDLE))
    else $error("controller did not return to idle after the final result");

  a_acc_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |=> (state == S_A_RD || state == S_SCAN))
    else $error("accumulate step left to an unexpected state");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_RD) |=> (state == S_B_RD))
    else $error("entry read not followed by the vector read");

endmodule

`default_nettype wire

FILE: design/smcm_datapath.sv
`default_nettype none

module smcm_datapath
  import smcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 cmd,
  input  wire logic [1:0]              req_type,
  input  wire logic [ROW_W-1:0]        row,
  input  wire logic [ROW_W-1:0]        col,
  input  wire logic signed [VAL_W-1:0] value,
  output dp_stat_t                     stat,
  output logic                         strobe,
  output logic [ROW_W-1:0]             out_row,
  output logic [ROW_W-1:0]             out_col,
  output logic signed [ACC_W-1:0]      out_value,
  output logic                         nonzero,
  output logic                         last,
  output logic                         overflow
);

  // Storage.
  a_entry_t                a_mem [NNZ_A];
  logic signed [VAL_W-1:0] b_mem [DIM];
  logic signed [ACC_W-1:0] c_mem [DIM];
  logic [DIM-1:0]          b_valid;
  logic [DIM-1:0]          c_valid;

  logic [CNT_W-1:0] a_count;
  logic             ovf_flag;
  logic [CNT_W-1:0] k;
  logic [IDX_W-1:0] scan_addr;
  logic [ROW_W-1:0] col_q;

  // Registered memory read data.
  a_entry_t                a_q;
  logic signed [VAL_W-1:0] b_rd_q;
  logic                    b_vq;
  logic signed [ACC_W-1:0] c_rd_q;
  logic                    c_vq;
  logic signed [PROD_W-1:0] prod;

  // Scan check stage and pending result.
  logic                    chk_vld;
  logic [IDX_W-1:0]        chk_row;
  logic                    pend_vld;
  logic [IDX_W-1:0]        pend_row;
  logic signed [ACC_W-1:0] pend_val;

  logic                    row_ok;
  logic                    col_ok;
  logic [IDX_W-1:0]        row_idx;
  logic [IDX_W-1:0]        c_rd_idx;
  logic signed [VAL_W-1:0] b_val;
  logic signed [ACC_W-1:0] c_cur;
  logic                    chk_nz;

  assign row_ok   = ({26'd0, row} < DIM);
  assign col_ok   = ({26'd0, col} < DIM);
  assign row_idx  = row[IDX_W-1:0];
  assign c_rd_idx = cmd.scan ? scan_addr : a_q.r[IDX_W-1:0];
  assign b_val    = b_vq ? b_rd_q : '0;
  assign c_cur    = c_vq ? c_rd_q : '0;
  assign chk_nz   = chk_vld && (c_cur != '0);

  assign stat.a_empty    = (a_count == '0);
  assign stat.entry_last = ((k + CNT_W'(1)) == a_count);
  assign stat.scan_last  = (scan_addr == IDX_W'(DIM - 1));

  // A store: written on accepted loads, read while walking.
  always_ff @(posedge clk) begin
    if (cmd.take && (req_type == REQ_LOAD_A) && row_ok && col_ok &&
        (a_count != CNT_W'(NNZ_A))) begin
      a_mem[a_count[A_AW-1:0]] <= '{r: row, c: col, v: value};
    end
    if (cmd.a_rd) begin
      a_q <= a_mem[k[A_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count  <= '0;
      ovf_flag <= 1'b0;
    end else if (cmd.take) begin
      if (req_type == REQ_LOAD_A && row_ok && col_ok) begin
        if (a_count == CNT_W'(NNZ_A)) begin
          ovf_flag <= 1'b1;
        end else begin
          a_count <= a_count + CNT_W'(1);
        end
      end else if (req_type == REQ_CLEAR) begin
        a_count  <= '0;
        ovf_flag <= 1'b0;
      end
    end
  end

  // B column vector.
  always_ff @(posedge clk) begin
    if (cmd.take && (req_type == REQ_LOAD_B) && row_ok) begin
      b_mem[row_idx] <= value;
    end
    if (cmd.b_rd) begin
      b_rd_q <= b_mem[a_q.c[IDX_W-1:0]];
      b_vq   <= b_valid[a_q.c[IDX_W-1:0]];
    end
  end

  // C column vector: read-modify-write per A entry, then scanned.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      c_mem[a_q.r[IDX_W-1:0]] <= c_cur + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (cmd.b_rd || cmd.scan) begin
      c_rd_q <= c_mem[c_rd_idx];
      c_vq   <= c_valid[c_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= '0;
      c_valid <= '0;
    end else if (cmd.fin) begin
      b_valid <= '0;
      c_valid <= '0;
    end else begin
      if (cmd.take && (req_type == REQ_LOAD_B) && row_ok) begin
        b_valid[row_idx] <= 1'b1;
      end
      if (cmd.acc) begin
        c_valid[a_q.r[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= a_q.v * b_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      scan_addr <= '0;
      chk_vld   <= 1'b0;
    end else begin
      chk_vld <= cmd.scan;
      if (cmd.init) begin
        k         <= '0;
        scan_addr <= '0;
      end else begin
        if (cmd.acc) begin
          k <= k + CNT_W'(1);
        end
        if (cmd.scan) begin
          scan_addr <= scan_addr + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      col_q <= col;
    end
    if (cmd.scan) begin
      chk_row <= scan_addr;
    end
  end

  // A nonzero row is held until the next one shows up, so that the final
  // one can carry the last mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.init) begin
        pend_vld <= 1'b0;
      end
      if (chk_nz) begin
        if (pend_vld) begin
          strobe    <= 1'b1;
          out_row   <= ROW_W'(pend_row);
          out_col   <= col_q;
          out_value <= pend_val;
          nonzero   <= 1'b1;
          last      <= 1'b0;
          overflow  <= ovf_flag;
        end
        pend_vld <= 1'b1;
        pend_row <= chk_row;
        pend_val <= c_cur;
      end
      if (cmd.fin) begin
        strobe    <= 1'b1;
        out_col   <= col_q;
        last      <= 1'b1;
        overflow  <= ovf_flag;
        if (pend_vld) begin
          out_row   <= ROW_W'(pend_row);
          out_value <= pend_val;
          nonzero   <= 1'b1;
        end else begin
          out_row   <= '0;
          out_value <= '0;
          nonzero   <= 1'b0;
        end
        pend_vld <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ovf_flag |-> (a_count == CNT_W'(NNZ_A)))
    else $error("overflow flag set while the A store has room");

  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !nonzero) |-> (last && out_value == '0))
    else $error("empty-column result without last mark");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> (b_valid == '0 && c_valid == '0 && !pend_vld))
    else $error("column vectors not cleared after the column");

endmodule

`default_nettype wire

FILE: design/sparse_matrix_column_multiply_core.sv
// Channel  Dir  Handshake           Fields
// command  in   start, busy         req_type, row, col, value
// result   out  strobe, one cycle   out_row, out_col, out_value, nonzero, last, overflow
//
// A command is transferred on a rising edge with start high and busy low; loads and
// clear keep busy low, so they can come back to back.
// An end-column command holds busy high while the controller walks the stored A
// entries (read, vector read, multiply, accumulate on the single C vector port for
// each), then the DIM-row scan, then one drain and one final state.
// Results leave on strobe for one cycle each; the receiver cannot stall them.
// Reset (rst, synchronous) empties the A store and zeroes both vectors.
`default_nettype none

module sparse_matrix_column_multiply_core
  import smcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              req_type,
  input  wire logic [ROW_W-1:0]        row,
  input  wire logic [ROW_W-1:0]        col,
  input  wire logic signed [VAL_W-1:0] value,
  output logic                         strobe,
  output logic [ROW_W-1:0]             out_row,
  output logic [ROW_W-1:0]             out_col,
  output logic signed [ACC_W-1:0]      out_value,
  output logic                         nonzero,
  output logic                         last,
  output logic                         overflow
);

  // Commands and status are the only link between sequencing and data.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller walks the stored A entries and then the C vector rows.
  smcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // The datapath holds the A store, both dense vectors, the multiplier and
  // the result registers. Untouched vector rows read as zero through
  // per-row valid bits, which are all cleared together after every column.
  smcm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (req_type),
    .row       (row),
    .col       (col),
    .value     (value),
    .stat      (stat),
    .strobe    (strobe),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .nonzero   (nonzero),
    .last      (last),
    .overflow  (overflow)
  );

endmodule

`default_nettype wire

FILE: test/smcm_column_check.sv
`default_nettype none

module smcm_column_check
  import smcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic [1:0]              req_type,
  input  wire logic [ROW_W-1:0]        row,
  input  wire logic [ROW_W-1:0]        col,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire logic                    strobe,
  input  wire logic [ROW_W-1:0]        out_row,
  input  wire logic [ROW_W-1:0]        out_col,
  input  wire logic signed [ACC_W-1:0] out_value,
  input  wire logic                    nonzero,
  input  wire logic                    last,
  input  wire logic                    overflow,
  output int                           mismatches,
  output int                           outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [ACC_W-1:0] sum;
    logic             nz;
    logic             fin;
    logic             ovf;
  } c_entry_t;

  // Shadow copy of the matrix state.
  a_entry_t                a_list [NNZ_A];
  int unsigned             a_used;
  logic signed [VAL_W-1:0] b_vec  [DIM];
  logic [ACC_W-1:0]        c_vec  [DIM];
  logic                    sticky_ovf;
  c_entry_t                c_pending [$];

  task automatic apply_command(input logic [1:0] kind, input logic [ROW_W-1:0] r,
                               input logic [ROW_W-1:0] c,
                               input logic signed [VAL_W-1:0] v);
    logic signed [PROD_W-1:0] prod;
    int                       top;
    case (kind)
      REQ_LOAD_A: begin
        if (r < DIM && c < DIM) begin
          if (a_used >= NNZ_A) begin
            sticky_ovf = 1'b1;
          end else begin
            a_list[a_used] = '{r: r, c: c, v: v};
            a_used++;
          end
        end
      end
      REQ_LOAD_B: begin
        if (r < DIM) b_vec[r] = v;
      end
      REQ_CLEAR: begin
        a_used     = 0;
        sticky_ovf = 1'b0;
      end
      REQ_END: begin
        for (int k = 0; k < a_used; k++) begin
          prod = a_list[k].v * b_vec[a_list[k].c];
          c_vec[a_list[k].r] = c_vec[a_list[k].r] +
                               {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
        top = -1;
        for (int i = 0; i < DIM; i++) begin
          if (c_vec[i] != '0) top = i;
        end
        if (top < 0) begin
          c_pending.push_back('{row: '0, col: c, sum: '0, nz: 1'b0, fin: 1'b1,
                                ovf: sticky_ovf});
        end
        for (int i = 0; i <= top; i++) begin
          if (c_vec[i] != '0) begin
            c_pending.push_back('{row: ROW_W'(i), col: c, sum: c_vec[i], nz: 1'b1,
                                  fin: (i == top), ovf: sticky_ovf});
          end
        end
        foreach (b_vec[i]) begin
          b_vec[i] = '0;
          c_vec[i] = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    c_entry_t want;
    c_entry_t got;
    if (rst) begin
      a_used     = 0;
      sticky_ovf = 1'b0;
      foreach (b_vec[i]) begin
        b_vec[i] = '0;
        c_vec[i] = '0;
      end
      c_pending.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (strobe) begin
        got = '{row: out_row, col: out_col, sum: out_value, nz: nonzero, fin: last,
                ovf: overflow};
        if (c_pending.size() == 0) begin
          $display("%0t: C entry with none outstanding: row %0d col %0d value %0d",
                   $time, out_row, out_col, out_value);
          mismatches++;
        end else begin
          want = c_pending.pop_front();
          if (got !== want) begin
            $display("%0t: C entry mismatch: expected row %0d col %0d value %0d nz %0b last %0b ovf %0b",
                     $time, want.row, want.col, $signed(want.sum), want.nz, want.fin,
                     want.ovf);
            $display("%0t:                     actual row %0d col %0d value %0d nz %0b last %0b ovf %0b",
                     $time, got.row, got.col, $signed(got.sum), got.nz, got.fin, got.ovf);
            mismatches++;
          end
        end
      end
      if (start && !busy) apply_command(req_type, row, col, value);
      outstanding <= c_pending.size();
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_sparse_matrix_column_multiply_core.sv
`default_nettype none

module tb_sparse_matrix_column_multiply_core;

  timeunit 1ns;
  timeprecision 1ps;

  import smcm_pkg::*;

  // The longest quiet stretch of a correct run is an end-column walk over a
  // full A store, with nothing transferred and no strobe. The limit leaves a
  // wide margin above that.
  localparam int WATCHDOG_LIMIT = 5 * (4 * NNZ_A + DIM + 2);
  localparam int RANDOM_ITEMS   = 480;
  localparam int CALM_AFTER     = 400;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic                    clk      = 1'b0;
  logic                    rst      = 1'b1;
  logic                    start    = 1'b0;
  logic [1:0]              req_type = REQ_LOAD_A;
  logic [ROW_W-1:0]        row      = '0;
  logic [ROW_W-1:0]        col      = '0;
  logic signed [VAL_W-1:0] value    = '0;

  logic                    busy;
  logic                    strobe;
  logic [ROW_W-1:0]        out_row;
  logic [ROW_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_value;
  logic                    nonzero;
  logic                    last;
  logic                    overflow;

  int mismatches;
  int outstanding;

  // Stimulus bookkeeping.
  bit gaps_on;
  int items_sent;
  int win_base;
  int win_span;
  int quiet_cycles;

  always #2 clk = ~clk;

  sparse_matrix_column_multiply_core DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .row      (row),
    .col      (col),
    .value    (value),
    .strobe   (strobe),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_value(out_value),
    .nonzero  (nonzero),
    .last     (last),
    .overflow (overflow)
  );

  // The column checker watches both channels, keeps its own copy of the A
  // store and the two column vectors, and reports how many C entries it is
  // still waiting for along with the failure count.
  smcm_column_check u_column_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .row        (row),
    .col        (col),
    .value      (value),
    .strobe     (strobe),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .nonzero    (nonzero),
    .last       (last),
    .overflow   (overflow),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Watchdog: any transfer or strobe counts as progress. A hang in busy or
  // a lost result ends the run here.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sparse_matrix_column_multiply_core regression: fail");
        $finish;
      end
    end
  end

  // Issues one command and returns in the time step of its transfer. Start
  // is left high so that back-to-back commands never lower and raise it in
  // the same step; only an idle burst drops it, and that burst always
  // advances the clock before start goes high again.
  task automatic send(input logic [1:0] kind, input logic [ROW_W-1:0] r,
                      input logic [ROW_W-1:0] c, input logic signed [VAL_W-1:0] v);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start    <= 1'b1;
    req_type <= kind;
    row      <= r;
    col      <= c;
    value    <= v;
    // busy is sampled before the edge updates it, so the edge at which it
    // reads low is the edge of the transfer.
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Holds the command side off until every outstanding C entry has come out.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Values lean on the extremes, zero and unit magnitudes, since those are
  // where sign extension and product width mistakes show up.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  // Indices come from a window so that A columns and B rows actually meet;
  // a narrow window also makes rows collide in the accumulator and lets
  // repeated B rows overwrite each other.
  function automatic logic [ROW_W-1:0] pick_index();
    return ROW_W'(win_base + $urandom_range(0, win_span));
  endfunction

  function automatic void pick_window();
    case ($urandom_range(0, 3))
      0:       win_span = 1;
      1:       win_span = 3;
      2:       win_span = 15;
      default: win_span = DIM - 1;
    endcase
    win_base = $urandom_range(0, DIM - 1 - win_span);
  endfunction

  initial begin
    int n_a;
    int n_cols;
    int n_b;
    gaps_on    = 1'b1;
    items_sent = 0;
    win_base   = 0;
    win_span   = DIM - 1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An end column straight out of reset sees empty
    // vectors and an empty store, so it yields the single all-zero marker.
    send(REQ_END, '0, 6'd63, '0);

    // Extreme operands in the corner rows and columns of A.
    send(REQ_LOAD_A, 6'd0,  6'd0,  VAL_MIN);
    send(REQ_LOAD_A, 6'd63, 6'd63, VAL_MAX);
    send(REQ_LOAD_A, 6'd63, 6'd0,  -16'sd1);
    send(REQ_LOAD_A, 6'd0,  6'd63, 16'sd1);
    send(REQ_LOAD_A, 6'd10, 6'd20, '0);

    // Row 63 of B is written twice; only the second value may count.
    send(REQ_LOAD_B, 6'd0,  '0, VAL_MIN);
    send(REQ_LOAD_B, 6'd63, '0, VAL_MAX);
    send(REQ_LOAD_B, 6'd63, '0, VAL_MIN);
    send(REQ_LOAD_B, 6'd20, '0, 16'sd5);
    send(REQ_END, '0, 6'd0, '0);

    // The vectors were cleared by the last end, so only row 0 matters now.
    send(REQ_LOAD_B, 6'd0, '0, 16'sd1);
    send(REQ_END, '0, 6'd5, '0);

    // B hits only the zero-valued A entry: A is populated but C is zero.
    send(REQ_LOAD_B, 6'd20, '0, VAL_MAX);
    send(REQ_END, '0, 6'd1, '0);

    // After a clear, a loaded B column finds no A entries at all.
    send(REQ_CLEAR, '0, '0, '0);
    send(REQ_LOAD_B, 6'd3, '0, 16'sd7);
    send(REQ_END, '0, 6'd2, '0);

    // Two products that cancel exactly in the same C row.
    send(REQ_LOAD_A, 6'd4, 6'd1, 16'sd3);
    send(REQ_LOAD_A, 6'd4, 6'd2, -16'sd3);
    send(REQ_LOAD_B, 6'd1, '0, 16'sd5);
    send(REQ_LOAD_B, 6'd2, '0, 16'sd5);
    send(REQ_END, '0, 6'd62, '0);
    drain();

    // Fill the A store to capacity with the most negative value at one spot.
    // With B at the same extreme every product is 2^30, and NNZ_A of them
    // wrap the 40-bit accumulator round to exactly zero, so the column
    // comes out as the all-zero marker. The loads past capacity set the
    // sticky overflow flag, which must show on every entry until cleared.
    send(REQ_CLEAR, '0, '0, '0);
    for (int i = 0; i < NNZ_A; i++) send(REQ_LOAD_A, 6'd5, 6'd7, VAL_MIN);
    send(REQ_LOAD_A, 6'd9, 6'd9, VAL_MAX);
    send(REQ_LOAD_A, 6'd1, 6'd7, 16'sd1);
    send(REQ_LOAD_B, 6'd7, '0, VAL_MIN);
    send(REQ_END, '0, 6'd9, '0);
    // Same store against the largest positive B value: the sum lands just
    // past the negative end and wraps to a small positive number.
    send(REQ_LOAD_B, 6'd7, '0, VAL_MAX);
    send(REQ_LOAD_B, 6'd5, '0, 16'sd1);
    send(REQ_END, '0, 6'd10, '0);
    send(REQ_CLEAR, '0, '0, '0);
    send(REQ_END, '0, 6'd11, '0);
    drain();

    // Random part. Most of it is well-formed: an optional clear, a batch of
    // A entries, then one to three B columns each closed by an end. The rest
    // is noise with any command in any order.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      gaps_on = (items_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      pick_window();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send(2'($urandom_range(0, 3)), 6'($urandom()), 6'($urandom()), pick_value());
        end
      end else begin
        if ($urandom_range(0, 3) == 0) send(REQ_CLEAR, 6'($urandom()), 6'($urandom()),
                                            pick_value());
        n_a = $urandom_range(0, 16);
        for (int i = 0; i < n_a; i++) begin
          send(REQ_LOAD_A, pick_index(), pick_index(), pick_value());
        end
        n_cols = $urandom_range(1, 3);
        for (int j = 0; j < n_cols; j++) begin
          n_b = $urandom_range(0, 8);
          for (int i = 0; i < n_b; i++) begin
            send(REQ_LOAD_B, pick_index(), 6'($urandom()), pick_value());
          end
          send(REQ_END, 6'($urandom()), 6'($urandom()), pick_value());
        end
      end
      if (items_sent < CALM_AFTER && $urandom_range(0, 11) == 0) drain();
    end

    // Let everything outstanding come out, then keep the clock running to
    // catch anything stray.
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2 * DIM) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("sparse_matrix_column_multiply_core regression: pass");
    end else begin
      $display("sparse_matrix_column_multiply_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
